// File: hdl/scu_pkg.sv
// Shared types, float32 constants and helper functions for the sine/cosine unit.
// Used by scu_fma, scu_out and float32_sin_cos_unit; depends on nothing else.
`timescale 1ns / 1ps
package scu_pkg;

	localparam logic [31:0] QNAN        = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
	localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
	localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
	localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;
	localparam logic [31:0] POS_ZERO    = 32'h0000_0000;
	localparam logic [31:0] QUAD_SCALE  = 32'h3F22_F983;
	localparam logic [31:0] PIO2_HI     = 32'hBFC9_0FD8;
	localparam logic [31:0] PIO2_MED    = 32'hB4A8_885A;
	localparam logic [31:0] PIO2_LO     = 32'hA7C2_34C4;
	localparam logic [31:0] RND_MAGIC   = 32'h4B40_0000;
	localparam logic [31:0] COS_C4      = 32'h37CC_730B;
	localparam logic [31:0] COS_C3      = 32'hBAB6_036E;
	localparam logic [31:0] COS_C2      = 32'h3D2A_AA9E;
	localparam logic [31:0] COS_C1      = 32'hBF00_0000;
	localparam logic [31:0] COS_C0      = 32'h3F80_0000;
	localparam logic [31:0] SIN_C4      = 32'h363E_9DDE;
	localparam logic [31:0] SIN_C3      = 32'hB950_35DD;
	localparam logic [31:0] SIN_C2      = 32'h3C08_88CD;
	localparam logic [31:0] SIN_C1      = 32'hBE2A_AAAB;

	localparam int NUM_STEPS = 16;

	// values that ride along the multiply-add chain
	typedef struct packed {
		logic        nf;   // angle was NaN or infinite
		logic [31:0] q;    // angle first, then the rounded quadrant value
		logic [31:0] r;    // reduced angle
		logic [31:0] sq;   // square of the reduced angle
		logic [31:0] cs;   // cosine polynomial
	} side_t;

	function automatic logic f_is_nan(input logic [31:0] x);
		return x[30:0] > INF_BITS[30:0];
	endfunction

	function automatic logic f_is_inf(input logic [31:0] x);
		return x[30:0] == INF_BITS[30:0];
	endfunction

	function automatic logic f_is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// leading zero count of a 64-bit word
	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 7'(63 - i);
		end
		return n;
	endfunction

	// integer part of an integral float, truncated, modulo four
	function automatic logic [1:0] quad_mod4(input logic [31:0] q);
		logic [7:0]  e;
		logic [23:0] sig;
		logic [1:0]  t;
		logic [4:0]  rs;
		e   = q[30:23];
		sig = {1'b1, q[22:0]};
		t   = 2'd0;
		rs  = 5'd0;
		if (e == 8'd0 || e == 8'hFF || e < 8'd127) begin
			t = 2'd0;
		end else if (e <= 8'd150) begin
			rs = 5'(8'd150 - e);
			t  = 2'(sig >> rs);
		end else if (e == 8'd151) begin
			t = {sig[0], 1'b0};
		end else begin
			t = 2'd0;
		end
		if (q[31]) t = 2'(3'd4 - {1'b0, t});
		return t;
	endfunction

	function automatic logic [31:0] pick(input logic [1:0] quad, input logic [31:0] s,
			input logic [31:0] c);
		logic [31:0] v;
		v = quad[0] ? c : s;
		if (f_is_nan(v)) return QNAN;
		return quad[1] ? (v ^ SIGN_BIT) : v;
	endfunction

endpackage

// File: hdl/scu_fma.sv
// Five-stage float32 fused multiply-add, round to nearest-even, one rounding.
// Carries a side_t record in step with the data; depends on scu_pkg.
`timescale 1ns / 1ps
module scu_fma import scu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  side_t       in_side,
	output logic        out_valid,
	output logic [31:0] result,
	output side_t       out_side
);

	// stage 1: specials, unpack, significand product
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        spec_s1, spec_s2, spec_s3, spec_s4;
	logic [31:0] sval_s1, sval_s2, sval_s3, sval_s4;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [47:0] p_s1;
	logic signed [11:0] pe_s1, ec_s1;
	logic [23:0] mc_s1;
	logic        sp_s1, sc_s1, cz_s1;

	logic        spec_c;
	logic [31:0] sval_c;
	logic [23:0] ma, mb, mc;
	logic signed [11:0] ea, eb, ec;
	logic        sp;

	always_comb begin
		sp     = a[31] ^ b[31];
		spec_c = 1'b1;
		sval_c = QNAN;
		if (f_is_nan(a) || f_is_nan(b) || f_is_nan(c)) begin
			sval_c = QNAN;
		end else if (f_is_inf(a) || f_is_inf(b)) begin
			if (f_is_zero(a) || f_is_zero(b)) sval_c = QNAN;
			else if (f_is_inf(c) && c[31] != sp) sval_c = QNAN;
			else sval_c = {sp, INF_BITS[30:0]};
		end else if (f_is_inf(c)) begin
			sval_c = c;
		end else if (f_is_zero(a) || f_is_zero(b)) begin
			if (f_is_zero(c)) sval_c = (sp == c[31]) ? {sp, 31'd0} : POS_ZERO;
			else sval_c = c;
		end else begin
			spec_c = 1'b0;
		end
		ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
		mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		mc = (c[30:23] == 8'd0) ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
		ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
		eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
		ec = (c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, c[30:23]}) - 12'sd150;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= spec_c;
			sval_s1 <= sval_c;
			side_s1 <= in_side;
			p_s1    <= ma * mb;
			pe_s1   <= ea + eb;
			mc_s1   <= mc;
			ec_s1   <= ec;
			sp_s1   <= sp;
			sc_s1   <= c[31];
			cz_s1   <= f_is_zero(c);
		end
	end

	// stage 2: normalize product and addend to a leading one
	logic [47:0] x_s2, y_s2;
	logic signed [11:0] xe_s2, ye_s2;
	logic        sp_s2, sc_s2, cz_s2;
	logic [6:0]  lzp, lzc_c;

	always_comb begin
		lzp   = lzc64({16'd0, p_s1}) - 7'd16;
		lzc_c = lzc64({40'd0, mc_s1}) - 7'd40;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
			side_s2 <= side_s1;
			x_s2    <= p_s1 << lzp[5:0];
			xe_s2   <= pe_s1 - $signed({5'd0, lzp});
			y_s2    <= {mc_s1 << lzc_c[4:0], 24'd0};
			ye_s2   <= ec_s1 - $signed({5'd0, lzc_c}) - 12'sd24;
			sp_s2   <= sp_s1;
			sc_s2   <= sc_s1;
			cz_s2   <= cz_s1;
		end
	end

	// stage 3: order, align with sticky, add or subtract
	logic [63:0] r_s3;
	logic signed [11:0] e_s3;
	logic        s_s3;
	logic        swp, bs;
	logic [47:0] bm, sm;
	logic signed [11:0] be3, se3, d;
	logic [63:0] bf, sf, lost, sum;
	logic        spec3;
	logic [31:0] sval3;

	always_comb begin
		swp  = (xe_s2 < ye_s2) || (xe_s2 == ye_s2 && x_s2 < y_s2);
		bm   = swp ? y_s2 : x_s2;
		sm   = swp ? x_s2 : y_s2;
		be3  = swp ? ye_s2 : xe_s2;
		se3  = swp ? xe_s2 : ye_s2;
		bs   = swp ? sc_s2 : sp_s2;
		d    = be3 - se3;
		bf   = {2'd0, bm, 14'd0};
		sf   = {2'd0, sm, 14'd0};
		lost = '0;
		if (d > 12'sd61) begin
			sf = 64'd1;
		end else if (d > 12'sd0) begin
			lost = sf & ((64'd1 << d[5:0]) - 64'd1);
			sf   = (sf >> d[5:0]) | {63'd0, lost != 64'd0};
		end
		sum   = (sp_s2 == sc_s2) ? bf + sf : bf - sf;
		spec3 = spec_s2;
		sval3 = sval_s2;
		if (cz_s2) begin
			sum = {2'd0, x_s2, 14'd0};
			be3 = xe_s2;
			bs  = sp_s2;
		end else if (!spec_s2 && sum == 64'd0) begin
			spec3 = 1'b1;
			sval3 = POS_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3 <= spec3;
			sval_s3 <= sval3;
			side_s3 <= side_s2;
			r_s3    <= sum;
			e_s3    <= be3 - 12'sd14;
			s_s3    <= bs;
		end
	end

	// stage 4: find the leading one of the sum
	logic [63:0] r_s4;
	logic signed [11:0] e_s4;
	logic        s_s4;
	logic [5:0]  k_s4;
	logic [6:0]  lz4;

	always_comb lz4 = lzc64(r_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4 <= spec_s3;
			sval_s4 <= sval_s3;
			side_s4 <= side_s3;
			r_s4    <= r_s3;
			e_s4    <= e_s3;
			s_s4    <= s_s3;
			k_s4    <= 6'(7'd63 - lz4);
		end
	end

	// stage 5: shift to 24 bits, round, pack
	logic [31:0] res5, res_s5;
	logic signed [11:0] sh, lim, qe, bex;
	logic [63:0] rs, mask;
	logic [24:0] qv;
	logic        g, st;
	logic [5:0]  shm1, nsh;

	always_comb begin
		sh   = $signed({6'd0, k_s4}) - 12'sd23;
		lim  = -12'sd149 - e_s4;
		if (lim > sh) sh = lim;
		g    = 1'b0;
		st   = 1'b0;
		rs   = '0;
		mask = '0;
		shm1 = 6'(sh - 12'sd1);
		nsh  = 6'(-sh);
		if (sh <= 12'sd0) begin
			qv = 25'(r_s4 << nsh);
		end else if (sh > 12'sd63) begin
			qv = '0;
		end else begin
			rs   = r_s4 >> shm1;
			g    = rs[0];
			qv   = 25'(rs >> 1);
			mask = (64'd1 << shm1) - 64'd1;
			st   = (r_s4 & mask) != 64'd0;
			if (g && (st || qv[0])) qv = qv + 25'd1;
			if (qv == 25'h100_0000) begin
				qv = qv >> 1;
				sh = sh + 12'sd1;
			end
		end
		qe  = e_s4 + sh;
		bex = qe + 12'sd150;
		if (qv[23]) begin
			if (bex >= 12'sd255) res5 = {s_s4, INF_BITS[30:0]};
			else res5 = {s_s4, bex[7:0], qv[22:0]};
		end else begin
			res5 = {s_s4, 8'd0, qv[22:0]};
		end
		if (spec_s4) res5 = sval_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5  <= res5;
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign result    = res_s5;
	assign out_side  = side_s5;

endmodule

// File: hdl/scu_out.sv
// Quadrant selection and output register with a skid entry for the result stream.
// Depends on scu_pkg (quad_mod4, pick, side_t).
`timescale 1ns / 1ps
module scu_out import scu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pipe_valid,
	input  logic [31:0] sn,
	input  side_t       pipe_side,
	output logic        en,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata
);

	logic        out_v_q, skid_v_q;
	logic [63:0] out_d_q, skid_d_q;
	logic [63:0] pipe_d;
	logic [1:0]  quad;

	// choose and sign the two results from the quadrant
	always_comb begin
		quad = quad_mod4(pipe_side.q);
		if (pipe_side.nf) pipe_d = {QNAN, QNAN};
		else pipe_d = {pick(2'(quad + 2'd1), sn, pipe_side.cs), pick(quad, sn, pipe_side.cs)};
	end

	// hold the chain only while the skid entry is full
	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (en && pipe_valid) skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_tready) begin
			if (en && pipe_valid) skid_d_q <= pipe_d;
		end else if (skid_v_q) begin
			out_d_q <= skid_d_q;
		end else begin
			out_d_q <= pipe_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid entry full while output empty");
	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid entry filled without a stalled output");
	a_nonfinite_qnan: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_valid && pipe_side.nf && !skid_v_q && !(out_v_q && !m_tready))
		|=> m_tdata == {QNAN, QNAN}) else $error("non-finite angle not mapped to NaN");

endmodule

// File: hdl/float32_sin_cos_unit.sv
// Top level: float32 sine and cosine by Cody-Waite reduction and polynomials.
// Chains sixteen scu_fma units and ends in scu_out; depends on scu_pkg.
//
//  port group   dir  width  contents
//  s_*          in   32     angle_bits
//  m_*          out  64     sine_bits, cosine_bits
//
// Data passes sixteen dependent multiply-adds of five stages each, then the
// output register. One transaction is accepted per cycle while s_tready is high.
// arst_n clears all valid bits; payload registers are not reset.
// The chain holds only when a result waits and the skid entry is full too;
// s_tready then drops for as long as the skid entry stays occupied.
`timescale 1ns / 1ps
module float32_sin_cos_unit import scu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] angle_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] sine_bits, [63:32] cosine_bits
);

	logic        en;
	logic [31:0] fa   [NUM_STEPS];
	logic [31:0] fb   [NUM_STEPS];
	logic [31:0] fc   [NUM_STEPS];
	side_t       fsd  [NUM_STEPS];
	logic        fv   [NUM_STEPS];
	logic [31:0] res  [NUM_STEPS];
	side_t       osd  [NUM_STEPS];
	logic        ov   [NUM_STEPS];

	// wire the operation sequence of each step
	always_comb begin
		for (int k = 0; k < NUM_STEPS; k++) begin
			fa[k]  = res[k > 0 ? k - 1 : 0];
			fb[k]  = ONE_BITS;
			fc[k]  = NEG_ZERO;
			fsd[k] = osd[k > 0 ? k - 1 : 0];
			fv[k]  = ov[k > 0 ? k - 1 : 0];
		end
		// scale by 2/pi
		fa[0]  = s_tdata;
		fb[0]  = QUAD_SCALE;
		fv[0]  = s_tvalid;
		fsd[0] = '{nf: s_tdata[30:23] == 8'hFF, q: s_tdata, r: '0, sq: '0, cs: '0};
		// round to an integer quadrant
		fc[1]  = RND_MAGIC;
		fc[2]  = RND_MAGIC ^ SIGN_BIT;
		// three-part reduction by pi/2
		fa[3]    = res[2];
		fb[3]    = PIO2_HI;
		fc[3]    = osd[2].q;
		fsd[3].q = res[2];
		fa[4]    = osd[3].q;
		fb[4]    = PIO2_MED;
		fc[4]    = res[3];
		fa[5]    = osd[4].q;
		fb[5]    = PIO2_LO;
		fc[5]    = res[4];
		// square of the reduced angle
		fa[6]    = res[5];
		fb[6]    = res[5];
		fsd[6].r = res[5];
		// cosine polynomial
		fa[7]     = COS_C4;
		fb[7]     = res[6];
		fc[7]     = COS_C3;
		fsd[7].sq = res[6];
		fb[8]     = osd[7].sq;
		fc[8]     = COS_C2;
		fb[9]     = osd[8].sq;
		fc[9]     = COS_C1;
		fb[10]    = osd[9].sq;
		fc[10]    = COS_C0;
		// sine polynomial
		fa[11]    = SIN_C4;
		fb[11]    = osd[10].sq;
		fc[11]    = SIN_C3;
		fsd[11].cs = res[10];
		fb[12]    = osd[11].sq;
		fc[12]    = SIN_C2;
		fb[13]    = osd[12].sq;
		fc[13]    = SIN_C1;
		fb[14]    = osd[13].sq;
		fc[14]    = POS_ZERO;
		fb[15]    = osd[14].r;
		fc[15]    = osd[14].r;
	end

	for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
		scu_fma u_fma (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (fv[k]),
			.a         (fa[k]),
			.b         (fb[k]),
			.c         (fc[k]),
			.in_side   (fsd[k]),
			.out_valid (ov[k]),
			.result    (res[k]),
			.out_side  (osd[k])
		);
	end

	scu_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (ov[NUM_STEPS-1]),
		.sn         (res[NUM_STEPS-1]),
		.pipe_side  (osd[NUM_STEPS-1]),
		.en         (en),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	assign s_tready = en;

endmodule
